>>> rtl/png_scanline_unfilter_macros.svh
// Assertion helpers for the RTL files; only pnguf_ctrl uses them
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset
`define PNGUF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pnguf assertion failed");
// Condition that must be followed by another in the next cycle
`define PNGUF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pnguf assertion failed");
`else
`define PNGUF_ASSERT(lbl, clk, rst, prop)
`define PNGUF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/pnguf_pkg.sv
package pnguf_pkg;

  localparam int MAX_ROW_BYTES   = 8192;
  localparam int MAX_PIXEL_BYTES = 8;

  localparam int LEN_W  = 14;
  localparam int DIST_W = 4;
  localparam int COL_W  = $clog2(MAX_ROW_BYTES);
  localparam int HIST_W = $clog2(MAX_PIXEL_BYTES);

  // Filter type codes
  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  // Register indexes
  localparam logic REG_ROW_LENGTH  = 1'b0;
  localparam logic REG_PIXEL_BYTES = 1'b1;

  // One result-producing item handed from the control stage to reconstruction
  typedef struct packed {
    logic [7:0]        data_byte;
    logic [2:0]        filter;
    logic              first_row;
    logic              use_left;
    logic [HIST_W-1:0] dist_idx;
    logic              last;
    logic              bad;
    logic [COL_W-1:0]  col;
  } pnguf_item_t;

  // Line memory write request
  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [7:0]       data;
  } pnguf_ram_wr_t;

endpackage

>>> rtl/pnguf_line_ram.sv
module pnguf_line_ram
  import pnguf_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [MAX_ROW_BYTES];

  // Write one byte of the current row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read of the row above
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pnguf_ctrl.sv
`include "png_scanline_unfilter_macros.svh"

module pnguf_ctrl
  import pnguf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        stream_byte,
  input  logic              image_start,
  input  logic [LEN_W-1:0]  row_length,
  input  logic [DIST_W-1:0] pixel_bytes,
  output logic              push,
  output pnguf_item_t       item
);

  logic [COL_W-1:0]  column, column_next;
  logic [2:0]        filter, filter_next;
  logic              awaiting, awaiting_next;
  logic              first_row, first_row_next;
  logic              halted, halted_next;

  logic [LEN_W-1:0]  eff_len;
  logic [DIST_W-1:0] eff_dist;
  logic [COL_W-1:0]  col;
  logic              last;
  logic              eff_first;
  logic              eff_await;

  // Clamp the register values into range
  always_comb begin
    if (row_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (row_length > LEN_W'(MAX_ROW_BYTES)) begin
      eff_len = LEN_W'(MAX_ROW_BYTES);
    end else begin
      eff_len = row_length;
    end
    if (pixel_bytes == '0) begin
      eff_dist = DIST_W'(1);
    end else if (pixel_bytes > DIST_W'(MAX_PIXEL_BYTES)) begin
      eff_dist = DIST_W'(MAX_PIXEL_BYTES);
    end else begin
      eff_dist = pixel_bytes;
    end
  end

  // Column of this byte and whether it closes the row
  always_comb begin
    if (LEN_W'(column) >= eff_len) begin
      col = COL_W'(eff_len - LEN_W'(1));
    end else begin
      col = column;
    end
    last = (LEN_W'(col) + LEN_W'(1)) >= eff_len;
  end

  // Decode the transaction: filter type, data byte or dropped
  always_comb begin
    eff_first      = image_start | first_row;
    eff_await      = image_start | awaiting;
    column_next    = column;
    filter_next    = filter;
    awaiting_next  = awaiting;
    first_row_next = first_row;
    halted_next    = halted;
    push           = 1'b0;

    item.data_byte = stream_byte;
    item.filter    = filter;
    item.first_row = eff_first;
    item.use_left  = LEN_W'(col) >= LEN_W'(eff_dist);
    item.dist_idx  = HIST_W'(eff_dist - DIST_W'(1));
    item.last      = last;
    item.bad       = 1'b0;
    item.col       = col;

    if (accept && !halted) begin
      if (eff_await) begin
        column_next    = '0;
        first_row_next = eff_first;
        if (stream_byte > {5'd0, FILT_PAETH}) begin
          halted_next = 1'b1;
          push        = 1'b1;
          item.bad    = 1'b1;
          item.last   = 1'b0;
        end else begin
          filter_next   = stream_byte[2:0];
          awaiting_next = 1'b0;
        end
      end else begin
        push = 1'b1;
        if (last) begin
          column_next    = '0;
          awaiting_next  = 1'b1;
          first_row_next = 1'b0;
        end else begin
          column_next = col + COL_W'(1);
        end
      end
    end
  end

  // Hold the scanline position
  always_ff @(posedge clk) begin
    if (rst) begin
      column    <= '0;
      filter    <= FILT_NONE;
      awaiting  <= 1'b1;
      first_row <= 1'b1;
      halted    <= 1'b0;
    end else begin
      column    <= column_next;
      filter    <= filter_next;
      awaiting  <= awaiting_next;
      first_row <= first_row_next;
      halted    <= halted_next;
    end
  end

  `PNGUF_ASSERT_NEXT(a_halt_sticky, clk, rst, halted, halted)
  `PNGUF_ASSERT_NEXT(a_bad_halts, clk, rst, push && item.bad, halted)
  `PNGUF_ASSERT(a_halt_silent, clk, rst, !(halted && push))
  `PNGUF_ASSERT_NEXT(a_last_awaits, clk, rst, push && item.last, awaiting)

endmodule

>>> rtl/pnguf_recon.sv
module pnguf_recon
  import pnguf_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pnguf_item_t   item,
  input  logic [7:0]    above_byte,
  output logic          in_ready,
  output pnguf_ram_wr_t ram_wr,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last,
  output logic          out_bad
);

  pnguf_item_t s1;
  logic        s1_valid;
  logic        s1_adv;

  logic [7:0]  left_hist [MAX_PIXEL_BYTES];
  logic [7:0]  ul_hist   [MAX_PIXEL_BYTES];

  logic [7:0]  a, b, c;
  logic [8:0]  avg_sum;
  logic [7:0]  pred;
  logic [7:0]  val;

  function automatic logic [7:0] paeth(input logic [7:0] pa_a, input logic [7:0] pa_b,
                                       input logic [7:0] pa_c);
    logic signed [9:0] d_bc;
    logic signed [9:0] d_ac;
    logic signed [9:0] d_sum;
    logic [9:0]        da;
    logic [9:0]        db;
    logic [9:0]        dc;
    d_bc  = $signed({2'b00, pa_b}) - $signed({2'b00, pa_c});
    d_ac  = $signed({2'b00, pa_a}) - $signed({2'b00, pa_c});
    d_sum = d_bc + d_ac;
    da    = d_bc[9]  ? 10'(-d_bc)  : 10'(d_bc);
    db    = d_ac[9]  ? 10'(-d_ac)  : 10'(d_ac);
    dc    = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);
    if (da <= db && da <= dc) begin
      return pa_a;
    end else if (db <= dc) begin
      return pa_b;
    end else begin
      return pa_c;
    end
  endfunction

  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  // Gather the neighbours of this byte
  always_comb begin
    b = s1.first_row ? 8'd0 : above_byte;
    a = s1.use_left ? left_hist[s1.dist_idx] : 8'd0;
    c = (s1.use_left && !s1.first_row) ? ul_hist[s1.dist_idx] : 8'd0;
  end

  // Predict and undo the filter
  always_comb begin
    avg_sum = {1'b0, a} + {1'b0, b};
    case (s1.filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: pred = paeth(a, b, c);
      default:    pred = 8'd0;
    endcase
    val = s1.data_byte + pred;
  end

  // Store the finished byte as the row above for the next scanline
  always_comb begin
    ram_wr.en   = s1_adv && !s1.bad;
    ram_wr.addr = s1.col;
    ram_wr.data = val;
  end

  // Hold one item in the working stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (push) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      s1 <= item;
    end
  end

  // Shift the left and upper-left histories one pixel byte along
  always_ff @(posedge clk) begin
    if (s1_adv && !s1.bad) begin
      for (int k = MAX_PIXEL_BYTES - 1; k > 0; k--) begin
        left_hist[k] <= left_hist[k-1];
        ul_hist[k]   <= ul_hist[k-1];
      end
      left_hist[0] <= val;
      ul_hist[0]   <= b;
    end
  end

  // Result register: advance on a free slot, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte <= s1.bad ? 8'd0 : val;
      out_last <= s1.last && !s1.bad;
      out_bad  <= s1.bad;
    end
  end

endmodule

>>> rtl/png_scanline_unfilter.sv
// PNG scanline reconstruction, one inflated byte per clock while not stalled.
// Input stream: s_tdata carries one byte of the inflated image stream,
// s_tuser marks the first byte of a new image. The first byte of every
// scanline is its filter type and gives no output; each data byte gives one
// reconstructed byte on the output stream, with m_tlast on the last byte of
// the scanline and m_tuser set for an unknown filter type.
// The user must write configuration (APB, byte address 0 row_length,
// 4 pixel_bytes) only while the block is idle; the block does not enforce it.
// Throughput: one transaction per cycle in both directions while the
// receiver does not stall. An accepted data byte passes a control stage that
// tracks the column and reads the previous row from the line memory, then a
// reconstruction stage feeding the output register that drives m_tvalid.
// When the receiver stalls, the output register and then the working stage
// fill, after which s_tready falls; nothing is lost.
// After an unknown filter type every later byte is taken and dropped until
// reset. Reset (synchronous, rst high) returns to awaiting a filter type on
// the first row of an image, with row_length and pixel_bytes at 1; the line
// memory is not cleared and needs no clearing pass.
module png_scanline_unfilter
  import pnguf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] stream_byte
  input  logic        s_tuser,   // [0] image_start
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] pixel_byte
  output logic        m_tlast,
  output logic        m_tuser,   // [0] bad_filter
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEN_W-1:0]  row_length;
  logic [DIST_W-1:0] pixel_bytes;
  logic              cfg_write;
  logic              accept;
  logic              push;
  pnguf_item_t       item;
  pnguf_ram_wr_t     ram_wr;
  logic [7:0]        above_byte;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign accept    = s_tvalid && s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length  <= LEN_W'(1);
      pixel_bytes <= DIST_W'(1);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ROW_LENGTH:  row_length  <= pwdata[LEN_W-1:0];
        REG_PIXEL_BYTES: pixel_bytes <= pwdata[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (paddr[2])
      REG_ROW_LENGTH:  prdata = {{(32-LEN_W){1'b0}}, row_length};
      REG_PIXEL_BYTES: prdata = {{(32-DIST_W){1'b0}}, pixel_bytes};
      default:         prdata = '0;
    endcase
  end

  pnguf_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (s_tdata),
    .image_start (s_tuser),
    .row_length  (row_length),
    .pixel_bytes (pixel_bytes),
    .push        (push),
    .item        (item)
  );

  pnguf_line_ram u_line_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (push),
    .rd_addr (item.col),
    .rd_data (above_byte)
  );

  pnguf_recon u_recon (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .above_byte (above_byte),
    .in_ready   (s_tready),
    .ram_wr     (ram_wr),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_bad    (m_tuser)
  );

endmodule
